>>> rtl/sha1md_pkg.sv
// Shared types, constants and helper functions of the SHA-1 message digest core.
package sha1md_pkg;

   // Number of compression rounds per 64-byte block.
   localparam int ROUNDS = 80;

   // Index of the last digest word.
   localparam logic [2:0] LAST_WORD = 3'd4;

   // Fill position at which the 64-bit length field starts.
   localparam logic [5:0] LEN_POS = 6'd56;

   // First padding byte.
   localparam logic [7:0] MARK_BYTE = 8'h80;

   // Source of the byte written into the block.
   typedef enum logic [1:0] {
      SEL_DATA,
      SEL_MARK,
      SEL_ZERO,
      SEL_LEN
   } byte_sel_type;

   // Round function group, one per twenty rounds.
   typedef enum logic [1:0] {
      PH_CHOOSE,
      PH_PARITY_LO,
      PH_MAJORITY,
      PH_PARITY_HI
   } phase_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic         load_byte;
      byte_sel_type byte_sel;
      logic         count_total;
      logic         load_len;
      logic         init_work;
      logic         round_en;
      logic         round_sched;
      phase_type    round_phase;
      logic         add_chain;
      logic         restart;
      logic [2:0]   word_sel;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic fill_last;
      logic fill_len;
   } status_type;

   // Initial chaining word for the given word position.
   function automatic logic [31:0] init_word(input logic [2:0] idx);
      logic [31:0] value;
      case (idx)
         3'd0:    value = 32'h67452301;
         3'd1:    value = 32'hefcdab89;
         3'd2:    value = 32'h98badcfe;
         3'd3:    value = 32'h10325476;
         3'd4:    value = 32'hc3d2e1f0;
         default: value = 32'h00000000;
      endcase
      return value;
   endfunction

   // Additive round constant of each group of twenty rounds.
   function automatic logic [31:0] round_const(input phase_type phase);
      logic [31:0] value;
      unique case (phase)
         PH_CHOOSE:    value = 32'h5a827999;
         PH_PARITY_LO: value = 32'h6ed9eba1;
         PH_MAJORITY:  value = 32'h8f1bbcdc;
         PH_PARITY_HI: value = 32'hca62c1d6;
         default:      value = 32'h00000000;
      endcase
      return value;
   endfunction

endpackage

>>> rtl/sha1md_datapath.sv
// Datapath of the SHA-1 core: block packing, message schedule, rounds and chaining words.
module sha1md_datapath
   import sha1md_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic [7:0]  data_byte,
   input  cmd_type     cmd,
   output status_type  status,
   output logic [31:0] digest_word
);

   logic [23:0] acc_ff, acc_in;
   logic [31:0] w_ff [16];
   logic [31:0] w_in [16];
   logic [31:0] a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0] a_in, b_in, c_in, d_in, e_in;
   logic [31:0] h_ff [5];
   logic [31:0] h_in [5];
   logic [60:0] total_ff, total_in;
   logic [5:0]  fill_ff, fill_in;
   logic [63:0] len_ff, len_in;

   logic [7:0]  byte_val;
   logic [31:0] new_word;
   logic        push_word;
   logic [31:0] sched_mix;
   logic [31:0] x_word;
   logic [31:0] f_val;
   logic [31:0] t_val;

   // Byte source selection.
   always_comb begin
      unique case (cmd.byte_sel)
         SEL_DATA: byte_val = data_byte;
         SEL_MARK: byte_val = MARK_BYTE;
         SEL_ZERO: byte_val = 8'h00;
         SEL_LEN:  byte_val = len_ff[63:56];
         default:  byte_val = 8'h00;
      endcase
   end

   // A word is complete when its fourth byte arrives.
   assign new_word  = {acc_ff, byte_val};
   assign push_word = cmd.load_byte && (fill_ff[1:0] == 2'b11);

   // Schedule word of this round: the stored word for the first sixteen rounds,
   // the expanded word afterwards.
   assign sched_mix = w_ff[13] ^ w_ff[8] ^ w_ff[2] ^ w_ff[0];
   assign x_word    = cmd.round_sched ? {sched_mix[30:0], sched_mix[31]} : w_ff[0];

   // Round function.
   always_comb begin
      unique case (cmd.round_phase)
         PH_CHOOSE:    f_val = (b_ff & c_ff) | (~b_ff & d_ff);
         PH_MAJORITY:  f_val = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
         PH_PARITY_LO,
         PH_PARITY_HI: f_val = b_ff ^ c_ff ^ d_ff;
         default:      f_val = b_ff ^ c_ff ^ d_ff;
      endcase
   end

   assign t_val = {a_ff[26:0], a_ff[31:27]} + f_val + e_ff
                  + round_const(cmd.round_phase) + x_word;

   // Byte accumulator and the sixteen-word schedule shift line.
   always_comb begin
      acc_in = acc_ff;
      if (cmd.load_byte) begin
         acc_in = {acc_ff[15:0], byte_val};
      end
      for (int i = 0; i < 15; i++) begin
         w_in[i] = w_ff[i];
      end
      w_in[15] = w_ff[15];
      if (push_word || cmd.round_en) begin
         for (int i = 0; i < 15; i++) begin
            w_in[i] = w_ff[i + 1];
         end
         w_in[15] = push_word ? new_word : x_word;
      end
   end

   // Working variables.
   always_comb begin
      a_in = a_ff;
      b_in = b_ff;
      c_in = c_ff;
      d_in = d_ff;
      e_in = e_ff;
      if (cmd.init_work) begin
         a_in = h_ff[0];
         b_in = h_ff[1];
         c_in = h_ff[2];
         d_in = h_ff[3];
         e_in = h_ff[4];
      end else if (cmd.round_en) begin
         a_in = t_val;
         b_in = a_ff;
         c_in = {b_ff[1:0], b_ff[31:2]};
         d_in = c_ff;
         e_in = d_ff;
      end
   end

   // Length field: loaded once per message, then shifted out a byte at a time.
   always_comb begin
      len_in = len_ff;
      if (cmd.load_len) begin
         len_in = {total_ff, 3'b000};
      end else if (cmd.load_byte && (cmd.byte_sel == SEL_LEN)) begin
         len_in = {len_ff[55:0], 8'h00};
      end
   end

   // Chaining words, byte total and fill position.
   always_comb begin
      for (int i = 0; i < 5; i++) begin
         h_in[i] = h_ff[i];
      end
      total_in = total_ff;
      fill_in  = fill_ff;
      if (cmd.restart) begin
         for (int i = 0; i < 5; i++) begin
            h_in[i] = init_word(3'(i));
         end
         total_in = '0;
         fill_in  = '0;
      end else begin
         if (cmd.add_chain) begin
            h_in[0] = h_ff[0] + a_ff;
            h_in[1] = h_ff[1] + b_ff;
            h_in[2] = h_ff[2] + c_ff;
            h_in[3] = h_ff[3] + d_ff;
            h_in[4] = h_ff[4] + e_ff;
         end
         if (cmd.count_total) begin
            total_in = total_ff + 61'd1;
         end
         if (cmd.load_byte) begin
            fill_in = fill_ff + 6'd1;
         end
      end
   end

   // Control state with reset values.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 5; i++) begin
            h_ff[i] <= init_word(3'(i));
         end
         total_ff <= '0;
         fill_ff  <= '0;
      end else begin
         h_ff     <= h_in;
         total_ff <= total_in;
         fill_ff  <= fill_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      w_ff   <= w_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      c_ff   <= c_in;
      d_ff   <= d_in;
      e_ff   <= e_in;
      len_ff <= len_in;
   end

   // Status and digest word selection.
   assign status.fill_last = (fill_ff == 6'd63);
   assign status.fill_len  = (fill_ff == LEN_POS);

   always_comb begin
      case (cmd.word_sel)
         3'd0:    digest_word = h_ff[0];
         3'd1:    digest_word = h_ff[1];
         3'd2:    digest_word = h_ff[2];
         3'd3:    digest_word = h_ff[3];
         3'd4:    digest_word = h_ff[4];
         default: digest_word = h_ff[0];
      endcase
   end

endmodule

>>> rtl/sha1md_ctrl.sv
// Controller of the SHA-1 core: input handshake, padding sequence, rounds and digest output.
module sha1md_ctrl
   import sha1md_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_byte_present,
   input  logic       req_end_of_message,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_word_index,
   output logic       rsp_final_word,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_ROUND = 7'b0000010,
      ST_ADD   = 7'b0000100,
      ST_MARK  = 7'b0001000,
      ST_ZERO  = 7'b0010000,
      ST_LEN   = 7'b0100000,
      ST_EMIT  = 7'b1000000
   } state_type;

   state_type   state_ff, state_in;
   state_type   after_ff, after_in;
   logic [6:0]  round_ff, round_in;
   logic [2:0]  word_ff, word_in;
   logic        accept;

   assign req_stall      = (state_ff != ST_IDLE);
   assign accept         = req_valid && (state_ff == ST_IDLE);
   assign rsp_valid      = (state_ff == ST_EMIT);
   assign rsp_word_index = word_ff;
   assign rsp_final_word = (word_ff == LAST_WORD);

   // Next state and datapath commands.
   always_comb begin
      state_in = state_ff;
      after_in = after_ff;
      round_in = round_ff;
      word_in  = word_ff;

      cmd          = '0;
      cmd.byte_sel = SEL_DATA;
      cmd.word_sel = word_ff;

      // Round group and schedule mode follow the round count.
      cmd.round_sched = (round_ff >= 7'd16);
      if (round_ff < 7'd20) begin
         cmd.round_phase = PH_CHOOSE;
      end else if (round_ff < 7'd40) begin
         cmd.round_phase = PH_PARITY_LO;
      end else if (round_ff < 7'd60) begin
         cmd.round_phase = PH_MAJORITY;
      end else begin
         cmd.round_phase = PH_PARITY_HI;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_byte_present) begin
                  cmd.load_byte   = 1'b1;
                  cmd.byte_sel    = SEL_DATA;
                  cmd.count_total = 1'b1;
               end
               if (req_byte_present && status.fill_last) begin
                  cmd.init_work = 1'b1;
                  state_in      = ST_ROUND;
                  after_in      = req_end_of_message ? ST_MARK : ST_IDLE;
               end else if (req_end_of_message) begin
                  state_in = ST_MARK;
               end
            end
         end
         ST_MARK: begin
            // Append the marker byte and capture the bit length.
            cmd.load_byte = 1'b1;
            cmd.byte_sel  = SEL_MARK;
            cmd.load_len  = 1'b1;
            if (status.fill_last) begin
               cmd.init_work = 1'b1;
               state_in      = ST_ROUND;
               after_in      = ST_ZERO;
            end else begin
               state_in = ST_ZERO;
            end
         end
         ST_ZERO: begin
            // Zero fill up to the length field.
            if (status.fill_len) begin
               state_in = ST_LEN;
            end else begin
               cmd.load_byte = 1'b1;
               cmd.byte_sel  = SEL_ZERO;
               if (status.fill_last) begin
                  cmd.init_work = 1'b1;
                  state_in      = ST_ROUND;
                  after_in      = ST_ZERO;
               end
            end
         end
         ST_LEN: begin
            // Length bytes, most significant first; the last one closes the block.
            cmd.load_byte = 1'b1;
            cmd.byte_sel  = SEL_LEN;
            if (status.fill_last) begin
               cmd.init_work = 1'b1;
               state_in      = ST_ROUND;
               after_in      = ST_EMIT;
            end
         end
         ST_ROUND: begin
            cmd.round_en = 1'b1;
            if (round_ff == 7'(ROUNDS - 1)) begin
               round_in = '0;
               state_in = ST_ADD;
            end else begin
               round_in = round_ff + 7'd1;
            end
         end
         ST_ADD: begin
            cmd.add_chain = 1'b1;
            state_in      = after_ff;
         end
         ST_EMIT: begin
            // One digest word per handshake; the last one restarts the message.
            if (!rsp_stall) begin
               if (word_ff == LAST_WORD) begin
                  cmd.restart = 1'b1;
                  word_in     = '0;
                  state_in    = ST_IDLE;
               end else begin
                  word_in = word_ff + 3'd1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         after_ff <= ST_IDLE;
         round_ff <= '0;
         word_ff  <= '0;
      end else begin
         state_ff <= state_in;
         after_ff <= after_in;
         round_ff <= round_in;
         word_ff  <= word_in;
      end
   end

endmodule

>>> rtl/sha1_message_digest_core.sv
// Top level of the SHA-1 message digest core.
//
// The request channel takes one message byte per word: req_data_byte is part of
// the message when req_byte_present is high, and req_end_of_message closes the
// message (with or without a byte of its own). A word is taken when req_valid is
// high and req_stall is low. The response channel gives the five digest words,
// most significant first, with their index and a flag on the fifth.
// An ordinary byte is stored and the core stays ready. The byte that fills a
// 64-byte block is stored, the 80 rounds of the single round unit run, and their
// result is added into the chaining words. A closing word then pads one byte per
// cycle while no block is compressed (marker, zero fill, a switch to the length,
// eight length bytes), runs one or two block compressions, and then presents the
// five digest words, one per cycle while rsp_stall is low. req_stall is high for
// all of that. A stall on the response side holds the current word until it is
// taken; the next message is accepted after the fifth word is taken.
// Reset loads the initial chaining words, clears the byte count and leaves the
// core idle and ready.
module sha1_message_digest_core
   import sha1md_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_present,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_final_word
);

   cmd_type    cmd;
   status_type status;

   // Sequencer.
   sha1md_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_byte_present   (req_byte_present),
      .req_end_of_message (req_end_of_message),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_word_index     (rsp_word_index),
      .rsp_final_word     (rsp_final_word),
      .status             (status),
      .cmd                (cmd)
   );

   // Hash datapath.
   sha1md_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .data_byte   (req_data_byte),
      .cmd         (cmd),
      .status      (status),
      .digest_word (rsp_digest_word)
   );

endmodule
